>>> rtl/core/ffpa_pkg.sv
// Shared types and constants of the first-fit partition allocator.
`default_nettype none
package ffpa_pkg;

  localparam int unsigned SizeW    = 16;
  localparam int unsigned ProcW    = 8;
  localparam int unsigned JobW     = 8;
  localparam int unsigned InitW    = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutIdxW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned MaxInitialDef = 32;

  localparam logic [SizeW-1:0] FirstSizeRst  = SizeW'(10);
  localparam logic [SizeW-1:0] SizeStepRst   = SizeW'(30);
  localparam logic [InitW-1:0] InitCountRst  = InitW'(20);

  localparam logic [CfgIdxW-1:0] CfgFirstSize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSizeStep  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgInitCount = CfgIdxW'(2);

  localparam logic OpRequest = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StNoOwner = 2'd2,
    StFull    = 2'd3
  } status_e;

  // command broadcast to every cell of the table
  typedef enum logic [2:0] {
    CellIdle,
    CellBuild,
    CellFit,
    CellOwn,
    CellSplit,
    CellTake,
    CellFree,
    CellClose
  } cell_op_e;

endpackage
`default_nettype wire

>>> rtl/core/ffpa_if.sv
// Request and response channel interfaces of the partition allocator.
`default_nettype none
interface ffpa_req_if import ffpa_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [ProcW-1:0] process_id;
  logic [JobW-1:0]  job_id;
  logic [SizeW-1:0] request_length;

  modport source (output valid, operation, process_id, job_id, request_length, input ready);
  modport sink   (input valid, operation, process_id, job_id, request_length, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [OutIdxW-1:0] entry_index;
  logic [SizeW-1:0]   start_offset;
  logic [SizeW-1:0]   block_size;

  modport source (output valid, status, entry_index, start_offset, block_size, input ready);
  modport sink   (input valid, status, entry_index, start_offset, block_size, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ffpa_cell.sv
// One table entry of the allocator, with its stage of the search and build wave.
`default_nettype none
module ffpa_cell import ffpa_pkg::*; #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned CW  = 7,
  parameter int unsigned OW  = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_op_e         op_i,
  input  wire logic [IW-1:0]    tgt_i,
  input  wire logic [CW-1:0]    cnt_i,
  input  wire logic [CW-1:0]    nbld_i,
  input  wire logic [SizeW-1:0] len_i,
  input  wire logic [SizeW-1:0] size_i,
  input  wire logic [SizeW-1:0] step_i,
  input  wire logic [ProcW-1:0] pid_i,
  input  wire logic [JobW-1:0]  jid_i,
  // left neighbor entry
  input  wire logic [OW-1:0]    l_org_i,
  input  wire logic [SizeW-1:0] l_off_i,
  input  wire logic [SizeW-1:0] l_size_i,
  input  wire logic             l_busy_i,
  input  wire logic [ProcW-1:0] l_pid_i,
  input  wire logic [JobW-1:0]  l_jid_i,
  // right neighbor entry
  input  wire logic [OW-1:0]    r_org_i,
  input  wire logic [SizeW-1:0] r_off_i,
  input  wire logic [SizeW-1:0] r_size_i,
  input  wire logic             r_busy_i,
  input  wire logic [ProcW-1:0] r_pid_i,
  input  wire logic [JobW-1:0]  r_jid_i,
  // own entry
  output logic [OW-1:0]         org_o,
  output logic [SizeW-1:0]      off_o,
  output logic [SizeW-1:0]      size_o,
  output logic                  busy_o,
  output logic [ProcW-1:0]      pid_o,
  output logic [JobW-1:0]       jid_o,
  // wave from the left
  input  wire logic             wi_tok_i,
  input  wire logic             wi_found_i,
  input  wire logic [IW-1:0]    wi_p_i,
  input  wire logic [SizeW-1:0] wi_off_i,
  input  wire logic [SizeW-1:0] wi_size_i,
  input  wire logic [OW-1:0]    wi_org_i,
  input  wire logic             wi_lbusy_i,
  input  wire logic [OW-1:0]    wi_lorg_i,
  input  wire logic [SizeW-1:0] wi_lsize_i,
  input  wire logic [SizeW-1:0] wi_loff_i,
  input  wire logic             wi_rbusy_i,
  input  wire logic [OW-1:0]    wi_rorg_i,
  input  wire logic [SizeW-1:0] wi_rsize_i,
  // wave to the right
  output logic                  wo_tok_o,
  output logic                  wo_found_o,
  output logic [IW-1:0]         wo_p_o,
  output logic [SizeW-1:0]      wo_off_o,
  output logic [SizeW-1:0]      wo_size_o,
  output logic [OW-1:0]         wo_org_o,
  output logic                  wo_lbusy_o,
  output logic [OW-1:0]         wo_lorg_o,
  output logic [SizeW-1:0]      wo_lsize_o,
  output logic [SizeW-1:0]      wo_loff_o,
  output logic                  wo_rbusy_o,
  output logic [OW-1:0]         wo_rorg_o,
  output logic [SizeW-1:0]      wo_rsize_o
);

  localparam logic [CW:0] IdxX = (CW+1)'(Idx);

  logic [OW-1:0]    org_q, org_d;
  logic [SizeW-1:0] off_q, off_d, size_q, size_d;
  logic             busy_q, busy_d;
  logic [ProcW-1:0] pid_q, pid_d;
  logic [JobW-1:0]  jid_q, jid_d;

  logic             tok_q, tok_d, found_q, found_d, lbusy_q, lbusy_d, rbusy_q, rbusy_d;
  logic [IW-1:0]    p_q, p_d;
  logic [SizeW-1:0] woff_q, woff_d, wsize_q, wsize_d, lsize_q, lsize_d;
  logic [SizeW-1:0] loff_q, loff_d, rsize_q, rsize_d;
  logic [OW-1:0]    worg_q, worg_d, lorg_q, lorg_d, rorg_q, rorg_d;

  logic [CW:0] cnt_x, tgt_x, tgt1_x;
  logic        in_tbl, nxt_in, in_bld, fit, own;

  always_comb begin
    cnt_x  = {1'b0, cnt_i};
    tgt_x  = (CW+1)'(tgt_i);
    tgt1_x = tgt_x + 1'b1;
    in_tbl = IdxX < cnt_x;
    nxt_in = (IdxX + 1'b1) < cnt_x;
    in_bld = IdxX < {1'b0, nbld_i};
    fit    = in_tbl && !busy_q && (size_q >= len_i);
    own    = in_tbl && busy_q && (pid_q == pid_i) && (jid_q == jid_i);
  end

  always_comb begin
    org_d  = org_q;
    off_d  = off_q;
    size_d = size_q;
    busy_d = busy_q;
    pid_d  = pid_q;
    jid_d  = jid_q;
    case (op_i)
      CellBuild: begin
        if (wi_tok_i) begin
          busy_d = 1'b0;
          if (in_bld) begin
            org_d  = OW'(Idx);
            off_d  = wi_off_i;
            size_d = wi_size_i;
          end
        end
      end
      CellSplit: begin
        if (IdxX == tgt_x) begin
          size_d = len_i;
          busy_d = 1'b1;
          pid_d  = pid_i;
          jid_d  = jid_i;
        end else if (IdxX == tgt1_x) begin
          // free remainder of the entry on the left
          org_d  = l_org_i;
          off_d  = l_off_i + len_i;
          size_d = l_size_i - len_i;
          busy_d = 1'b0;
        end else if (IdxX > tgt1_x && IdxX <= cnt_x) begin
          org_d  = l_org_i;
          off_d  = l_off_i;
          size_d = l_size_i;
          busy_d = l_busy_i;
          pid_d  = l_pid_i;
          jid_d  = l_jid_i;
        end
      end
      CellTake: begin
        if (IdxX == tgt_x) begin
          busy_d = 1'b1;
          pid_d  = pid_i;
          jid_d  = jid_i;
        end
      end
      CellFree: begin
        if (IdxX == tgt_x) begin
          busy_d = 1'b0;
          size_d = size_i;
        end
      end
      CellClose: begin
        if (IdxX >= tgt_x && nxt_in) begin
          org_d  = r_org_i;
          off_d  = r_off_i;
          size_d = r_size_i;
          busy_d = r_busy_i;
          pid_d  = r_pid_i;
          jid_d  = r_jid_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tok_d   = wi_tok_i;
    found_d = wi_found_i;
    p_d     = wi_p_i;
    woff_d  = wi_off_i;
    wsize_d = wi_size_i;
    worg_d  = wi_org_i;
    lbusy_d = wi_lbusy_i;
    lorg_d  = wi_lorg_i;
    lsize_d = wi_lsize_i;
    loff_d  = wi_loff_i;
    rbusy_d = wi_rbusy_i;
    rorg_d  = wi_rorg_i;
    rsize_d = wi_rsize_i;
    case (op_i)
      CellBuild: begin
        woff_d  = wi_off_i + wi_size_i;
        wsize_d = wi_size_i + step_i;
      end
      CellFit: begin
        if (wi_tok_i && !wi_found_i && fit) begin
          found_d = 1'b1;
          p_d     = IW'(Idx);
          woff_d  = off_q;
          wsize_d = size_q;
          worg_d  = org_q;
        end
      end
      CellOwn: begin
        // last match wins, neighbors captured along with it
        if (wi_tok_i && own) begin
          found_d = 1'b1;
          p_d     = IW'(Idx);
          woff_d  = off_q;
          wsize_d = size_q;
          worg_d  = org_q;
          lbusy_d = l_busy_i;
          lorg_d  = l_org_i;
          lsize_d = l_size_i;
          loff_d  = l_off_i;
          rbusy_d = r_busy_i || !nxt_in;
          rorg_d  = r_org_i;
          rsize_d = r_size_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    org_q   <= org_d;
    off_q   <= off_d;
    size_q  <= size_d;
    pid_q   <= pid_d;
    jid_q   <= jid_d;
    found_q <= found_d;
    p_q     <= p_d;
    woff_q  <= woff_d;
    wsize_q <= wsize_d;
    worg_q  <= worg_d;
    lbusy_q <= lbusy_d;
    lorg_q  <= lorg_d;
    lsize_q <= lsize_d;
    loff_q  <= loff_d;
    rbusy_q <= rbusy_d;
    rorg_q  <= rorg_d;
    rsize_q <= rsize_d;
  end

  assign org_o      = org_q;
  assign off_o      = off_q;
  assign size_o     = size_q;
  assign busy_o     = busy_q;
  assign pid_o      = pid_q;
  assign jid_o      = jid_q;
  assign wo_tok_o   = tok_q;
  assign wo_found_o = found_q;
  assign wo_p_o     = p_q;
  assign wo_off_o   = woff_q;
  assign wo_size_o  = wsize_q;
  assign wo_org_o   = worg_q;
  assign wo_lbusy_o = lbusy_q;
  assign wo_lorg_o  = lorg_q;
  assign wo_lsize_o = lsize_q;
  assign wo_loff_o  = loff_q;
  assign wo_rbusy_o = rbusy_q;
  assign wo_rorg_o  = rorg_q;
  assign wo_rsize_o = rsize_q;

endmodule
`default_nettype wire

>>> rtl/core/first_fit_partition_allocator.sv
// First-fit partition allocator: the table is a row of MAX_ENTRIES cells, one entry each.
// A search token walks the row one cell per clock through every cell for each request or
// release; then the entry is split, taken or freed, and the row shifts by one cell for
// each merged neighbor; a refused item skips the update. The result is handed over once
// the previous one has left the response channel, and the next item is taken when idle.
// A new item is accepted while the previous result still waits on the response channel.
// After reset and after every write to a known configuration register the table is
// rebuilt by a wave that runs down the row; no item is taken until the build is done.
`default_nettype none
module first_fit_partition_allocator import ffpa_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned MAX_INITIAL = MaxInitialDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ffpa_req_if.sink                 req_i,
  ffpa_rsp_if.source               rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OW   = (MAX_INITIAL > 1) ? $clog2(MAX_INITIAL) : 1;
  localparam int unsigned NMax = (MAX_INITIAL < MAX_ENTRIES) ? MAX_INITIAL : MAX_ENTRIES;

  typedef enum logic [2:0] {
    StBuild, StIdle, StScan, StApply, StClose, StDone
  } state_e;

  state_e           state_q, state_d;
  logic [SizeW-1:0] first_q, first_d, step_q, step_d;
  logic [InitW-1:0] init_q, init_d;
  logic             start_q, start_d;
  logic [CW-1:0]    bld_q, bld_d, cnt_q, cnt_d;
  logic             op_q, op_d;
  logic [ProcW-1:0] pid_q, pid_d;
  logic [JobW-1:0]  jid_q, jid_d;
  logic [SizeW-1:0] len_q, len_d, nsize_q, nsize_d;
  cell_op_e         cop_q, cop_d;
  logic [IW-1:0]    tgt_q, tgt_d, cltgt_q, cltgt_d;
  logic [1:0]       ncl_q, ncl_d;
  status_e          res_st_q, res_st_d;
  logic [IW-1:0]    res_idx_q, res_idx_d;
  logic [SizeW-1:0] res_off_q, res_off_d, res_size_q, res_size_d;
  logic             ovld_q, ovld_d;
  status_e          ost_q, ost_d;
  logic [OutIdxW-1:0] oidx_q, oidx_d;
  logic [SizeW-1:0] ooff_q, ooff_d, osize_q, osize_d;

  logic [CW-1:0]    n_bld;
  cell_op_e         cell_op;
  logic [IW-1:0]    cell_tgt;
  logic             mr, ml;

  // entry rows, with a busy boundary cell on each side
  logic [OW-1:0]    e_org  [MAX_ENTRIES+2];
  logic [SizeW-1:0] e_off  [MAX_ENTRIES+2];
  logic [SizeW-1:0] e_size [MAX_ENTRIES+2];
  logic             e_busy [MAX_ENTRIES+2];
  logic [ProcW-1:0] e_pid  [MAX_ENTRIES+2];
  logic [JobW-1:0]  e_jid  [MAX_ENTRIES+2];

  logic             w_tok   [MAX_ENTRIES+1];
  logic             w_found [MAX_ENTRIES+1];
  logic [IW-1:0]    w_p     [MAX_ENTRIES+1];
  logic [SizeW-1:0] w_off   [MAX_ENTRIES+1];
  logic [SizeW-1:0] w_size  [MAX_ENTRIES+1];
  logic [OW-1:0]    w_org   [MAX_ENTRIES+1];
  logic             w_lbusy [MAX_ENTRIES+1];
  logic [OW-1:0]    w_lorg  [MAX_ENTRIES+1];
  logic [SizeW-1:0] w_lsize [MAX_ENTRIES+1];
  logic [SizeW-1:0] w_loff  [MAX_ENTRIES+1];
  logic             w_rbusy [MAX_ENTRIES+1];
  logic [OW-1:0]    w_rorg  [MAX_ENTRIES+1];
  logic [SizeW-1:0] w_rsize [MAX_ENTRIES+1];

  assign e_org[0]              = '0;
  assign e_off[0]              = '0;
  assign e_size[0]             = '0;
  assign e_busy[0]             = 1'b1;
  assign e_pid[0]              = '0;
  assign e_jid[0]              = '0;
  assign e_org[MAX_ENTRIES+1]  = '0;
  assign e_off[MAX_ENTRIES+1]  = '0;
  assign e_size[MAX_ENTRIES+1] = '0;
  assign e_busy[MAX_ENTRIES+1] = 1'b1;
  assign e_pid[MAX_ENTRIES+1]  = '0;
  assign e_jid[MAX_ENTRIES+1]  = '0;

  assign w_tok[0]   = start_q;
  assign w_found[0] = 1'b0;
  assign w_p[0]     = '0;
  assign w_off[0]   = '0;
  assign w_size[0]  = first_q;
  assign w_org[0]   = '0;
  assign w_lbusy[0] = 1'b1;
  assign w_lorg[0]  = '0;
  assign w_lsize[0] = '0;
  assign w_loff[0]  = '0;
  assign w_rbusy[0] = 1'b1;
  assign w_rorg[0]  = '0;
  assign w_rsize[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    ffpa_cell #(.Idx(g), .IW(IW), .CW(CW), .OW(OW)) u_cell (
      .clk_i, .rst_ni,
      .op_i(cell_op), .tgt_i(cell_tgt), .cnt_i(cnt_q), .nbld_i(n_bld),
      .len_i(len_q), .size_i(nsize_q), .step_i(step_q), .pid_i(pid_q), .jid_i(jid_q),
      .l_org_i(e_org[g]), .l_off_i(e_off[g]), .l_size_i(e_size[g]),
      .l_busy_i(e_busy[g]), .l_pid_i(e_pid[g]), .l_jid_i(e_jid[g]),
      .r_org_i(e_org[g+2]), .r_off_i(e_off[g+2]), .r_size_i(e_size[g+2]),
      .r_busy_i(e_busy[g+2]), .r_pid_i(e_pid[g+2]), .r_jid_i(e_jid[g+2]),
      .org_o(e_org[g+1]), .off_o(e_off[g+1]), .size_o(e_size[g+1]),
      .busy_o(e_busy[g+1]), .pid_o(e_pid[g+1]), .jid_o(e_jid[g+1]),
      .wi_tok_i(w_tok[g]), .wi_found_i(w_found[g]), .wi_p_i(w_p[g]),
      .wi_off_i(w_off[g]), .wi_size_i(w_size[g]), .wi_org_i(w_org[g]),
      .wi_lbusy_i(w_lbusy[g]), .wi_lorg_i(w_lorg[g]), .wi_lsize_i(w_lsize[g]),
      .wi_loff_i(w_loff[g]), .wi_rbusy_i(w_rbusy[g]), .wi_rorg_i(w_rorg[g]),
      .wi_rsize_i(w_rsize[g]),
      .wo_tok_o(w_tok[g+1]), .wo_found_o(w_found[g+1]), .wo_p_o(w_p[g+1]),
      .wo_off_o(w_off[g+1]), .wo_size_o(w_size[g+1]), .wo_org_o(w_org[g+1]),
      .wo_lbusy_o(w_lbusy[g+1]), .wo_lorg_o(w_lorg[g+1]), .wo_lsize_o(w_lsize[g+1]),
      .wo_loff_o(w_loff[g+1]), .wo_rbusy_o(w_rbusy[g+1]), .wo_rorg_o(w_rorg[g+1]),
      .wo_rsize_o(w_rsize[g+1])
    );
  end

  always_comb begin
    if (init_q == '0) begin
      n_bld = CW'(1);
    end else if (int'(init_q) > NMax) begin
      n_bld = CW'(NMax);
    end else begin
      n_bld = CW'(init_q);
    end
  end

  always_comb begin
    cell_op  = CellIdle;
    cell_tgt = tgt_q;
    unique case (state_q)
      StBuild: cell_op = CellBuild;
      StScan:  cell_op = (op_q == OpRelease) ? CellOwn : CellFit;
      StApply: cell_op = cop_q;
      StClose: begin
        cell_op  = CellClose;
        cell_tgt = cltgt_q;
      end
      default: ;
    endcase
  end

  // merge conditions, valid when the search token leaves the last cell
  assign mr = !w_rbusy[MAX_ENTRIES] && (w_rorg[MAX_ENTRIES] == w_org[MAX_ENTRIES]);
  assign ml = !w_lbusy[MAX_ENTRIES] && (w_lorg[MAX_ENTRIES] == w_org[MAX_ENTRIES]);

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    step_d     = step_q;
    init_d     = init_q;
    start_d    = 1'b0;
    bld_d      = bld_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    pid_d      = pid_q;
    jid_d      = jid_q;
    len_d      = len_q;
    nsize_d    = nsize_q;
    cop_d      = cop_q;
    tgt_d      = tgt_q;
    cltgt_d    = cltgt_q;
    ncl_d      = ncl_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    res_off_d  = res_off_q;
    res_size_d = res_size_q;
    ovld_d     = ovld_q && !rsp_o.ready;
    ost_d      = ost_q;
    oidx_d     = oidx_q;
    ooff_d     = ooff_q;
    osize_d    = osize_q;

    unique case (state_q)
      StBuild: begin
        cnt_d = n_bld;
        bld_d = bld_q + 1'b1;
        if (bld_q == CW'(MAX_ENTRIES)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_i.valid) begin
          op_d    = req_i.operation;
          pid_d   = req_i.process_id;
          jid_d   = req_i.job_id;
          len_d   = req_i.request_length;
          start_d = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (w_tok[MAX_ENTRIES]) begin
          res_st_d   = StOk;
          res_idx_d  = '0;
          res_off_d  = '0;
          res_size_d = '0;
          ncl_d      = 2'd0;
          state_d    = StApply;
          if (!w_found[MAX_ENTRIES]) begin
            res_st_d = (op_q == OpRelease) ? StNoOwner : StNoFit;
            state_d  = StDone;
          end else if (op_q == OpRequest) begin
            tgt_d      = w_p[MAX_ENTRIES];
            res_idx_d  = w_p[MAX_ENTRIES];
            res_off_d  = w_off[MAX_ENTRIES];
            res_size_d = len_q;
            if (w_size[MAX_ENTRIES] > len_q) begin
              cop_d = CellSplit;
              if (cnt_q >= CW'(MAX_ENTRIES)) begin
                res_st_d   = StFull;
                res_idx_d  = '0;
                res_off_d  = '0;
                res_size_d = '0;
                state_d    = StDone;
              end
            end else begin
              cop_d = CellTake;
            end
          end else begin
            cop_d   = CellFree;
            ncl_d   = {1'b0, mr} + {1'b0, ml};
            tgt_d   = w_p[MAX_ENTRIES];
            cltgt_d = w_p[MAX_ENTRIES] + 1'b1;
            nsize_d = w_size[MAX_ENTRIES] + (mr ? w_rsize[MAX_ENTRIES] : '0);
            res_off_d = w_off[MAX_ENTRIES];
            if (ml) begin
              tgt_d     = w_p[MAX_ENTRIES] - 1'b1;
              cltgt_d   = w_p[MAX_ENTRIES];
              nsize_d   = w_lsize[MAX_ENTRIES] + w_size[MAX_ENTRIES]
                        + (mr ? w_rsize[MAX_ENTRIES] : '0);
              res_off_d = w_loff[MAX_ENTRIES];
            end
            res_idx_d  = tgt_d;
            res_size_d = nsize_d;
          end
        end
      end
      StApply: begin
        if (cop_q == CellSplit) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = (ncl_q != 2'd0) ? StClose : StDone;
      end
      StClose: begin
        cnt_d = cnt_q - 1'b1;
        ncl_d = ncl_q - 1'b1;
        if (ncl_q == 2'd1) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ost_d   = res_st_q;
          oidx_d  = OutIdxW'(res_idx_q);
          ooff_d  = res_off_q;
          osize_d = res_size_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // a write to a known register rebuilds the table
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFirstSize: first_d = SizeW'(cfg_data_i);
        CfgSizeStep:  step_d  = SizeW'(cfg_data_i);
        CfgInitCount: init_d  = cfg_data_i[InitW-1:0];
        default: ;
      endcase
      if (cfg_idx_i == CfgFirstSize || cfg_idx_i == CfgSizeStep ||
          cfg_idx_i == CfgInitCount) begin
        state_d = StBuild;
        start_d = 1'b1;
        bld_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StBuild;
      first_q <= FirstSizeRst;
      step_q  <= SizeStepRst;
      init_q  <= InitCountRst;
      start_q <= 1'b1;
      bld_q   <= '0;
      cnt_q   <= '0;
      ncl_q   <= 2'd0;
      cop_q   <= CellIdle;
      op_q    <= OpRequest;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      step_q  <= step_d;
      init_q  <= init_d;
      start_q <= start_d;
      bld_q   <= bld_d;
      cnt_q   <= cnt_d;
      ncl_q   <= ncl_d;
      cop_q   <= cop_d;
      op_q    <= op_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q      <= pid_d;
    jid_q      <= jid_d;
    len_q      <= len_d;
    nsize_q    <= nsize_d;
    tgt_q      <= tgt_d;
    cltgt_q    <= cltgt_d;
    res_st_q   <= res_st_d;
    res_idx_q  <= res_idx_d;
    res_off_q  <= res_off_d;
    res_size_q <= res_size_d;
    ost_q      <= ost_d;
    oidx_q     <= oidx_d;
    ooff_q     <= ooff_d;
    osize_q    <= osize_d;
  end

  assign req_i.ready        = (state_q == StIdle);
  assign rsp_o.valid        = ovld_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.entry_index  = oidx_q;
  assign rsp_o.start_offset = ooff_q;
  assign rsp_o.block_size   = osize_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !cfg_we_i) |=> (state_q == StScan && start_q))
    else $error("accepted item did not start a search");

  a_close_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClose) |-> (cnt_q > CW'(1)))
    else $error("merge with fewer than two entries");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && !ovld_q && !cfg_we_i) |=> ovld_q)
    else $error("finished item not presented");

endmodule
`default_nettype wire
